// ===== design/gidm_pkg.sv =====
// gidm_pkg: shared types and constants for the group id match table
// holds entry layout, operation and outcome codes and sequencer states
// no dependencies
`default_nettype none

package gidm_pkg;

	localparam int unsigned ID_W     = 32;
	localparam int unsigned STATUS_W = 40;
	localparam int unsigned RES_W    = 6;

	typedef struct packed {
		logic [ID_W-1:0]     id;
		logic [STATUS_W-1:0] status;
	} entry_t;

	typedef enum logic [1:0] {
		FUNC_ADD    = 2'd0,
		FUNC_DEL    = 2'd1,
		FUNC_CLR    = 2'd2,
		FUNC_LOOKUP = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		OUT_DONE = 2'd0,
		OUT_DUP  = 2'd1,
		OUT_MISS = 2'd2,
		OUT_FULL = 2'd3
	} outcome_t;

	typedef enum logic [1:0] {
		ST_IDLE   = 2'd0,
		ST_SEARCH = 2'd1,
		ST_FINISH = 2'd2,
		ST_SHIFT  = 2'd3
	} state_t;

endpackage

`default_nettype wire

// ===== design/gidm_store.sv =====
// gidm_store: entry memory, one write port and one registered read port
// depends on gidm_pkg for the entry layout
`default_nettype none

module gidm_store #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned AW    = 5
) (
	input  wire logic            clk,
	input  wire logic            we,
	input  wire logic [AW-1:0]   waddr,
	input  wire gidm_pkg::entry_t wdata,
	input  wire logic [AW-1:0]   raddr,
	output gidm_pkg::entry_t     rdata
);

	gidm_pkg::entry_t mem_q [DEPTH];
	gidm_pkg::entry_t rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire

// ===== design/gidm_ctrl.sv =====
// gidm_ctrl: sequencer with the shared id comparator, entry count and result registers
// drives gidm_store one entry per cycle for search and delete shift
// depends on gidm_pkg
`default_nettype none

module gidm_ctrl #(
	parameter int unsigned DEPTH = 32,
	parameter int unsigned AW    = 5
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [1:0]                      func,
	input  wire logic [gidm_pkg::ID_W-1:0]       group_id,
	input  wire logic [gidm_pkg::STATUS_W-1:0]   status_in,
	output logic                                 done,
	output logic                                 found,
	output logic [gidm_pkg::RES_W-1:0]           position,
	output logic [gidm_pkg::STATUS_W-1:0]        status_out,
	output logic [gidm_pkg::RES_W-1:0]           entry_total,
	output logic [1:0]                           outcome,
	output logic                                 mem_we,
	output logic [AW-1:0]                        mem_waddr,
	output gidm_pkg::entry_t                     mem_wdata,
	output logic [AW-1:0]                        mem_raddr,
	input  wire gidm_pkg::entry_t                mem_rdata
);

	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam int unsigned PW = (CW > gidm_pkg::RES_W) ? CW : gidm_pkg::RES_W;

	gidm_pkg::state_t                  state_q, state_d;
	gidm_pkg::func_t                   func_q;
	logic [gidm_pkg::ID_W-1:0]         id_q;
	logic [gidm_pkg::STATUS_W-1:0]     status_in_q;
	logic [AW-1:0]                     idx_q, idx_d;
	logic                              hit_q, hit_d;
	logic [gidm_pkg::RES_W-1:0]        pos_q, pos_d;
	logic [gidm_pkg::STATUS_W-1:0]     match_st_q, match_st_d;
	logic [CW-1:0]                     count_q, count_d;
	logic                              load_req;
	logic                              emit;
	gidm_pkg::outcome_t                res_outcome;
	logic [gidm_pkg::STATUS_W-1:0]     res_status;
	logic [CW-1:0]                     idx_plus1, idx_plus2;
	logic [PW-1:0]                     pos_w, total_w;
	logic                              done_q;
	logic                              found_q;
	logic [gidm_pkg::RES_W-1:0]        position_q, entry_total_q;
	logic [gidm_pkg::STATUS_W-1:0]     status_out_q;
	gidm_pkg::outcome_t                outcome_q;

	assign idx_plus1 = CW'(idx_q) + CW'(1);
	assign idx_plus2 = CW'(idx_q) + CW'(2);
	assign pos_w     = PW'(idx_q) + PW'(1);
	assign total_w   = PW'(count_d);

	always_comb begin
		state_d     = state_q;
		idx_d       = idx_q;
		hit_d       = hit_q;
		pos_d       = pos_q;
		match_st_d  = match_st_q;
		count_d     = count_q;
		load_req    = 1'b0;
		emit        = 1'b0;
		res_outcome = gidm_pkg::OUT_DONE;
		res_status  = '0;
		mem_we      = 1'b0;
		mem_waddr   = idx_q;
		mem_wdata   = mem_rdata;
		mem_raddr   = '0;
		case (state_q)
			gidm_pkg::ST_IDLE: begin
				if (start) begin
					load_req = 1'b1;
					idx_d    = '0;
					hit_d    = 1'b0;
					pos_d    = '0;
					state_d  = (count_q == '0) ? gidm_pkg::ST_FINISH : gidm_pkg::ST_SEARCH;
				end
			end
			gidm_pkg::ST_SEARCH: begin
				if (mem_rdata.id == id_q) begin
					hit_d      = 1'b1;
					pos_d      = pos_w[gidm_pkg::RES_W-1:0];
					match_st_d = mem_rdata.status;
					state_d    = gidm_pkg::ST_FINISH;
				end else if (idx_plus1 < count_q) begin
					idx_d     = idx_plus1[AW-1:0];
					mem_raddr = idx_plus1[AW-1:0];
				end else begin
					state_d = gidm_pkg::ST_FINISH;
				end
			end
			gidm_pkg::ST_FINISH: begin
				case (func_q)
					gidm_pkg::FUNC_ADD: begin
						emit = 1'b1;
						if (hit_q) begin
							res_outcome = gidm_pkg::OUT_DUP;
						end else if (count_q >= CW'(DEPTH)) begin
							res_outcome = gidm_pkg::OUT_FULL;
						end else begin
							mem_we    = 1'b1;
							mem_waddr = count_q[AW-1:0];
							mem_wdata = '{id: id_q, status: status_in_q};
							count_d   = count_q + CW'(1);
						end
					end
					gidm_pkg::FUNC_DEL: begin
						if (!hit_q) begin
							emit        = 1'b1;
							res_outcome = gidm_pkg::OUT_MISS;
						end else if (idx_plus1 < count_q) begin
							mem_raddr = idx_plus1[AW-1:0];
							state_d   = gidm_pkg::ST_SHIFT;
						end else begin
							emit    = 1'b1;
							count_d = count_q - CW'(1);
						end
					end
					gidm_pkg::FUNC_CLR: begin
						emit    = 1'b1;
						count_d = '0;
					end
					default: begin
						emit = 1'b1;
						if (hit_q) begin
							res_status = match_st_q;
						end else begin
							res_outcome = gidm_pkg::OUT_MISS;
						end
					end
				endcase
			end
			gidm_pkg::ST_SHIFT: begin
				mem_we    = 1'b1;
				mem_waddr = idx_q;
				mem_wdata = mem_rdata;
				if (idx_plus2 < count_q) begin
					idx_d     = idx_plus1[AW-1:0];
					mem_raddr = idx_plus2[AW-1:0];
				end else begin
					emit    = 1'b1;
					count_d = count_q - CW'(1);
				end
			end
			default: begin
				state_d = gidm_pkg::ST_IDLE;
			end
		endcase
		if (emit) begin
			state_d = gidm_pkg::ST_IDLE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= gidm_pkg::ST_IDLE;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			done_q  <= emit;
		end
	end

	always_ff @(posedge clk) begin
		idx_q      <= idx_d;
		hit_q      <= hit_d;
		pos_q      <= pos_d;
		match_st_q <= match_st_d;
		if (load_req) begin
			func_q      <= gidm_pkg::func_t'(func);
			id_q        <= group_id;
			status_in_q <= status_in;
		end
		if (emit) begin
			found_q       <= hit_q;
			position_q    <= pos_q;
			status_out_q  <= res_status;
			entry_total_q <= total_w[gidm_pkg::RES_W-1:0];
			outcome_q     <= res_outcome;
		end
	end

	assign busy        = (state_q != gidm_pkg::ST_IDLE);
	assign done        = done_q;
	assign found       = found_q;
	assign position    = position_q;
	assign status_out  = status_out_q;
	assign entry_total = entry_total_q;
	assign outcome     = outcome_q;

	// a finished request always reports as the sequencer goes idle
	a_done_on_idle: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(busy) |-> done)
		else $error("busy dropped without a result");

	// no two results back to back
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe held for two cycles");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count above depth");

	a_full_means_full: assert property (@(posedge clk) disable iff (!arst_n)
		done && (outcome_q == gidm_pkg::OUT_FULL) |-> count_q == CW'(DEPTH))
		else $error("full reported on a table with room");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("request accepted but sequencer idle");

endmodule

`default_nettype wire

// ===== design/group_id_match_table.sv =====
// group_id_match_table: top level, sequencer plus entry memory
// depends on gidm_pkg, gidm_store and gidm_ctrl
//
// A request (func, group_id, status_in) is taken when start is high and busy is low.
// The table is searched one entry per cycle through a single id comparator, lowest
// position first; a delete then moves each later entry down one place, again one entry
// per cycle through the store's write and read ports. Search and shift together touch
// each entry at most once, followed by a decide step and a report step; an empty table
// goes straight to the decide step. The result is shown for exactly one cycle with done
// high and cannot be held off, so it must be captured then. busy is low in the done cycle
// and a new request may start there.
`default_nettype none

module group_id_match_table #(
	parameter int unsigned DEPTH = 32
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            start,
	output logic                                 busy,
	input  wire logic [1:0]                      func,
	input  wire logic [gidm_pkg::ID_W-1:0]       group_id,
	input  wire logic [gidm_pkg::STATUS_W-1:0]   status_in,
	output logic                                 done,
	output logic                                 found,
	output logic [gidm_pkg::RES_W-1:0]           position,
	output logic [gidm_pkg::STATUS_W-1:0]        status_out,
	output logic [gidm_pkg::RES_W-1:0]           entry_total,
	output logic [1:0]                           outcome
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic              mem_we;
	logic [AW-1:0]     mem_waddr;
	logic [AW-1:0]     mem_raddr;
	gidm_pkg::entry_t  mem_wdata;
	gidm_pkg::entry_t  mem_rdata;

	gidm_ctrl #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.func        (func),
		.group_id    (group_id),
		.status_in   (status_in),
		.done        (done),
		.found       (found),
		.position    (position),
		.status_out  (status_out),
		.entry_total (entry_total),
		.outcome     (outcome),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_raddr   (mem_raddr),
		.mem_rdata   (mem_rdata)
	);

	gidm_store #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_store (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// tb: self-checking testbench for group_id_match_table
// predicts every request with its own copy of the table and checks each done strobe
// depends on gidm_pkg and group_id_match_table
`default_nettype none

module tb;

	localparam int TABLE_DEPTH = 32;
	localparam int CYCLE_LIMIT = 300000;
	localparam int SETTLE_CYCLES = 40;

	typedef struct packed {
		logic                          found;
		logic [gidm_pkg::RES_W-1:0]    position;
		logic [gidm_pkg::STATUS_W-1:0] status;
		logic [gidm_pkg::RES_W-1:0]    total;
		gidm_pkg::outcome_t            outcome;
	} reply_t;

	logic                          clk = 1'b0;
	logic                          arst_n = 1'b0;
	logic                          start = 1'b0;
	gidm_pkg::func_t               req_func = gidm_pkg::FUNC_LOOKUP;
	logic [gidm_pkg::ID_W-1:0]     req_id = '0;
	logic [gidm_pkg::STATUS_W-1:0] req_status = '0;
	logic                          busy;
	logic                          done;
	logic                          found;
	logic [gidm_pkg::RES_W-1:0]    position;
	logic [gidm_pkg::STATUS_W-1:0] status_out;
	logic [gidm_pkg::RES_W-1:0]    entry_total;
	logic [1:0]                    outcome;

	logic [gidm_pkg::ID_W-1:0]     tbl_id [TABLE_DEPTH];
	logic [gidm_pkg::STATUS_W-1:0] tbl_status [TABLE_DEPTH];
	int                            tbl_count = 0;
	reply_t                        pending_replies [$];
	int                            mismatch_count = 0;
	int                            cycle_count = 0;
	bit                            idle_allowed = 1'b1;
	bit                            idle_on = 1'b1;

	group_id_match_table #(
		.DEPTH(TABLE_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.func(req_func),
		.group_id(req_id),
		.status_in(req_status),
		.done(done),
		.found(found),
		.position(position),
		.status_out(status_out),
		.entry_total(entry_total),
		.outcome(outcome)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	task automatic predict_table_op(input gidm_pkg::func_t f,
			input logic [gidm_pkg::ID_W-1:0] id,
			input logic [gidm_pkg::STATUS_W-1:0] st);
		reply_t r;
		int     hit;
		hit = 0;
		for (int i = 0; i < tbl_count; i++) begin
			if (hit == 0 && tbl_id[i] == id)
				hit = i + 1;
		end
		r = '0;
		r.found = (hit != 0);
		r.position = hit[gidm_pkg::RES_W-1:0];
		r.outcome = gidm_pkg::OUT_DONE;
		case (f)
			gidm_pkg::FUNC_ADD: begin
				if (hit != 0)
					r.outcome = gidm_pkg::OUT_DUP;
				else if (tbl_count >= TABLE_DEPTH)
					r.outcome = gidm_pkg::OUT_FULL;
				else begin
					tbl_id[tbl_count] = id;
					tbl_status[tbl_count] = st;
					tbl_count++;
				end
			end
			gidm_pkg::FUNC_DEL: begin
				if (hit == 0)
					r.outcome = gidm_pkg::OUT_MISS;
				else begin
					for (int i = hit - 1; i + 1 < tbl_count; i++) begin
						tbl_id[i] = tbl_id[i + 1];
						tbl_status[i] = tbl_status[i + 1];
					end
					tbl_count--;
				end
			end
			gidm_pkg::FUNC_CLR: tbl_count = 0;
			default: begin
				if (hit == 0)
					r.outcome = gidm_pkg::OUT_MISS;
				else
					r.status = tbl_status[hit - 1];
			end
		endcase
		r.total = tbl_count[gidm_pkg::RES_W-1:0];
		pending_replies.push_back(r);
	endtask

	// start is left high unless an idle gap drops it, so back-to-back needs no reassign
	task automatic send_request(input gidm_pkg::func_t f,
			input logic [gidm_pkg::ID_W-1:0] id,
			input logic [gidm_pkg::STATUS_W-1:0] st);
		req_func <= f;
		req_id <= id;
		req_status <= st;
		start <= 1'b1;
		do
			@(posedge clk);
		while (busy);
		predict_table_op(f, id, st);
		if (idle_allowed && idle_on && $urandom_range(0, 2) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic wait_all_replies();
		start <= 1'b0;
		while (pending_replies.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin : check_replies
		reply_t w;
		if (arst_n && done) begin
			if (pending_replies.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display({"reply with no request pending: ",
						"found=%0d pos=%0d status=%h total=%0d outcome=%0d"},
						found, position, status_out, entry_total, outcome);
			end else begin
				w = pending_replies.pop_front();
				if (found !== w.found || position !== w.position ||
						status_out !== w.status || entry_total !== w.total ||
						outcome !== w.outcome) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display({"reply mismatch: exp found=%0d pos=%0d status=%h ",
							"total=%0d outcome=%0d, got found=%0d pos=%0d ",
							"status=%h total=%0d outcome=%0d"},
							w.found, w.position, w.status, w.total, w.outcome,
							found, position, status_out, entry_total, outcome);
				end
			end
		end
	end

	function automatic logic [gidm_pkg::STATUS_W-1:0] rand_status();
		return {8'($urandom()), 32'($urandom())};
	endfunction

	function automatic logic [gidm_pkg::ID_W-1:0] pick_group_id();
		int sel;
		sel = $urandom_range(0, 99);
		if (tbl_count > 0 && sel < 60)
			return tbl_id[$urandom_range(0, tbl_count - 1)];
		else if (sel < 75)
			return gidm_pkg::ID_W'($urandom_range(0, 15));
		return $urandom();
	endfunction

	task automatic test_empty_table();
		send_request(gidm_pkg::FUNC_LOOKUP, '0, '0);
		send_request(gidm_pkg::FUNC_DEL, '1, '1);
		send_request(gidm_pkg::FUNC_CLR, 32'h1234_5678, '0);
		send_request(gidm_pkg::FUNC_ADD, '0, '0);
		send_request(gidm_pkg::FUNC_ADD, '1, '1);
		send_request(gidm_pkg::FUNC_LOOKUP, '1, '0);
		send_request(gidm_pkg::FUNC_LOOKUP, '0, '1);
		send_request(gidm_pkg::FUNC_ADD, '0, 40'ha5_5aa5_5aa5);
		send_request(gidm_pkg::FUNC_LOOKUP, '0, '0);
		wait_all_replies();
	endtask

	task automatic test_delete_shift();
		send_request(gidm_pkg::FUNC_CLR, '0, '0);
		for (int i = 0; i < 5; i++)
			send_request(gidm_pkg::FUNC_ADD, 32'hc0de_0000 + i, rand_status());
		send_request(gidm_pkg::FUNC_DEL, 32'hc0de_0002, '0);
		send_request(gidm_pkg::FUNC_LOOKUP, 32'hc0de_0003, '0);
		send_request(gidm_pkg::FUNC_DEL, 32'hc0de_0000, '0);
		send_request(gidm_pkg::FUNC_DEL, 32'hc0de_0004, '0);
		send_request(gidm_pkg::FUNC_DEL, 32'hc0de_0002, '0);
		send_request(gidm_pkg::FUNC_LOOKUP, 32'hc0de_0001, '0);
		send_request(gidm_pkg::FUNC_LOOKUP, 32'hc0de_0003, '0);
		wait_all_replies();
	endtask

	task automatic test_clear_search();
		send_request(gidm_pkg::FUNC_CLR, 32'hc0de_0003, '0);
		send_request(gidm_pkg::FUNC_LOOKUP, 32'hc0de_0003, '0);
		wait_all_replies();
	endtask

	task automatic test_fill_to_full();
		logic [gidm_pkg::ID_W-1:0] last_id;
		int                        tries;
		tries = 0;
		last_id = '0;
		send_request(gidm_pkg::FUNC_CLR, '0, '0);
		while (tbl_count < TABLE_DEPTH && tries < 200) begin
			last_id = $urandom();
			send_request(gidm_pkg::FUNC_ADD, last_id, rand_status());
			tries++;
		end
		send_request(gidm_pkg::FUNC_ADD, ~last_id, rand_status());
		send_request(gidm_pkg::FUNC_ADD, last_id, rand_status());
		send_request(gidm_pkg::FUNC_LOOKUP, last_id, '0);
		send_request(gidm_pkg::FUNC_DEL, last_id, '0);
		send_request(gidm_pkg::FUNC_ADD, ~last_id, '1);
		send_request(gidm_pkg::FUNC_LOOKUP, ~last_id, '0);
		send_request(gidm_pkg::FUNC_DEL, tbl_id[0], '0);
		wait_all_replies();
	endtask

	task automatic test_random_mix(input int n_items, input int add_w, input int del_w,
			input int clr_w);
		int              sel;
		gidm_pkg::func_t f;
		for (int k = 0; k < n_items; k++) begin
			sel = $urandom_range(0, 99);
			if (sel < add_w)
				f = gidm_pkg::FUNC_ADD;
			else if (sel < add_w + del_w)
				f = gidm_pkg::FUNC_DEL;
			else if (sel < add_w + del_w + clr_w)
				f = gidm_pkg::FUNC_CLR;
			else
				f = gidm_pkg::FUNC_LOOKUP;
			if ($urandom_range(0, 39) == 0)
				idle_on = !idle_on;
			send_request(f, pick_group_id(), rand_status());
		end
		wait_all_replies();
	endtask

	initial begin
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_empty_table();
		test_delete_shift();
		test_clear_search();
		test_fill_to_full();
		test_random_mix(250, 60, 10, 1);
		test_random_mix(250, 35, 25, 3);
		test_random_mix(150, 20, 50, 2);
		idle_allowed = 1'b0;
		test_random_mix(230, 45, 20, 2);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (pending_replies.size() != 0)
			mismatch_count++;
		if (mismatch_count == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule

`default_nettype wire
